[rtl/sse_pkg.sv]
`default_nettype none

package sse_pkg;

    // fixed field widths of the ports
    localparam int KIND_W    = 2;
    localparam int IN_VAL_W  = 32;
    localparam int STAT_W    = 2;
    localparam int POS_W     = 6;
    localparam int CNT_OUT_W = 7;
    localparam int SUM_W     = 38;

    // defaults for the top level parameters
    localparam int DEF_CAPACITY    = 64;
    localparam int DEF_VALUE_WIDTH = 32;

    // operation codes on the input beat
    localparam logic [KIND_W-1:0] KIND_INS  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DEL  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SRCH = 2'd2;

    // status codes on the result beat
    localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NOCHG = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

    // update command for the cell row
    typedef logic [1:0] t_op;
    localparam t_op OP_NONE = 2'd0;
    localparam t_op OP_INS  = 2'd1;
    localparam t_op OP_DEL  = 2'd2;

    typedef struct packed {
        logic cmp;
        t_op  op;
    } t_cell_cmd;

    typedef struct packed {
        logic vld;
        logic lt;
        logic eq;
    } t_cell_stat;

endpackage

`default_nettype wire

[rtl/sse_cell.sv]
`default_nettype none

module sse_cell
    import sse_pkg::*;
#(
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  t_cell_cmd                     i_cmd,
    input  wire signed [VALUE_WIDTH-1:0]  i_key,
    input  wire signed [VALUE_WIDTH-1:0]  i_left_val,
    input  wire                           i_left_vld,
    input  wire                           i_left_lt,
    input  wire signed [VALUE_WIDTH-1:0]  i_right_val,
    input  wire                           i_right_vld,
    output logic signed [VALUE_WIDTH-1:0] o_val,
    output t_cell_stat                    o_stat
);

    logic signed [VALUE_WIDTH-1:0] r_val;
    logic signed [VALUE_WIDTH-1:0] n_val;
    logic                          r_vld;
    logic                          n_vld;
    logic                          r_lt;
    logic                          r_eq;

    always_comb begin
        n_val = r_val;
        n_vld = r_vld;
        unique case (i_cmd.op)
            OP_INS: begin
                // cells at or past the slot move one place up, the slot takes the key
                if (!r_lt) begin
                    n_val = i_left_lt ? i_key : i_left_val;
                end
                n_vld = r_vld | i_left_vld;
            end
            OP_DEL: begin
                if (!r_lt) begin
                    n_val = i_right_val;
                    n_vld = i_right_vld;
                end
            end
            default: begin
                n_val = r_val;
                n_vld = r_vld;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
            r_lt  <= 1'b0;
            r_eq  <= 1'b0;
        end else begin
            r_vld <= n_vld;
            if (i_cmd.cmp) begin
                r_lt <= r_vld && (r_val < i_key);
                r_eq <= r_vld && (r_val == i_key);
            end
        end
    end

    assign o_val      = r_val;
    assign o_stat.vld = r_vld;
    assign o_stat.lt  = r_lt;
    assign o_stat.eq  = r_eq;

endmodule

`default_nettype wire

[rtl/sorted_set_engine_unit.sv]
`default_nettype none

// channel   direction  handshake            payload
// input     in         i_valid / o_stall    i_kind, i_value
// result    out        o_valid / i_stall    o_status, o_position, o_member_count, o_member_sum
//
// each item passes in turn through accept, compare in every cell, decide, shift the row
// the row of CAPACITY cells compares and shifts in parallel, so the time does not
// grow with the count; o_stall is high from accept until the row has been updated
// synchronous active-low reset empties the set and clears count and sum
// a stalled result holds the row in its update cycle until the result is taken

module sorted_set_engine_unit
    import sse_pkg::*;
#(
    parameter int CAPACITY    = DEF_CAPACITY,
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_valid,
    output logic                       o_stall,
    input  wire        [KIND_W-1:0]    i_kind,
    input  wire signed [IN_VAL_W-1:0]  i_value,
    output logic                       o_valid,
    input  wire                        i_stall,
    output logic       [STAT_W-1:0]    o_status,
    output logic       [POS_W-1:0]     o_position,
    output logic       [CNT_OUT_W-1:0] o_member_count,
    output logic signed [SUM_W-1:0]    o_member_sum
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CMP  = 2'd1;
    localparam logic [1:0] ST_DEC  = 2'd2;
    localparam logic [1:0] ST_UPD  = 2'd3;

    logic [1:0]                    r_state;
    logic [1:0]                    n_state;
    logic [KIND_W-1:0]             r_kind;
    logic signed [VALUE_WIDTH-1:0] r_key;
    t_op                           r_op;
    logic [STAT_W-1:0]             r_stat;
    logic [IDX_W-1:0]              r_pos;
    logic signed [SUM_W-1:0]       r_delta;
    logic [CNT_W-1:0]              r_count;
    logic [CNT_W-1:0]              n_count;
    logic signed [SUM_W-1:0]       r_sum;
    logic signed [SUM_W-1:0]       n_sum;

    logic                          r_ovalid;
    logic [STAT_W-1:0]             r_o_status;
    logic [POS_W-1:0]              r_o_pos;
    logic [CNT_OUT_W-1:0]          r_o_count;
    logic signed [SUM_W-1:0]       r_o_sum;

    logic                          in_beat;
    logic                          upd_fire;
    t_cell_cmd                     cmd;

    logic signed [VALUE_WIDTH-1:0] cell_val [CAPACITY];
    t_cell_stat                    stat     [CAPACITY];
    logic signed [VALUE_WIDTH-1:0] left_val [CAPACITY];
    logic                          left_vld [CAPACITY];
    logic                          left_lt  [CAPACITY];
    logic signed [VALUE_WIDTH-1:0] right_val[CAPACITY];
    logic                          right_vld[CAPACITY];

    logic                          found;
    logic                          full;
    logic [IDX_W-1:0]              slot;
    t_op                           dec_op;
    logic [STAT_W-1:0]             dec_stat;
    logic signed [SUM_W-1:0]       key_ext;

    assign o_stall  = (r_state != ST_IDLE);
    assign in_beat  = i_valid && !o_stall;
    assign upd_fire = (r_state == ST_UPD) && (!r_ovalid || !i_stall);

    always_comb begin
        cmd.cmp = (r_state == ST_CMP);
        cmd.op  = upd_fire ? r_op : OP_NONE;
    end

    // neighbor wiring of the row; the first cell sees an always-smaller left side
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        if (i == 0) begin : g_first
            assign left_val[i] = r_key;
            assign left_vld[i] = 1'b1;
            assign left_lt[i]  = 1'b1;
        end else begin : g_mid
            assign left_val[i] = cell_val[i-1];
            assign left_vld[i] = stat[i-1].vld;
            assign left_lt[i]  = stat[i-1].lt;
        end
        if (i == CAPACITY - 1) begin : g_last
            assign right_val[i] = r_key;
            assign right_vld[i] = 1'b0;
        end else begin : g_inner
            assign right_val[i] = cell_val[i+1];
            assign right_vld[i] = stat[i+1].vld;
        end

        sse_cell #(
            .VALUE_WIDTH (VALUE_WIDTH)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_cmd       (cmd),
            .i_key       (r_key),
            .i_left_val  (left_val[i]),
            .i_left_vld  (left_vld[i]),
            .i_left_lt   (left_lt[i]),
            .i_right_val (right_val[i]),
            .i_right_vld (right_vld[i]),
            .o_val       (cell_val[i]),
            .o_stat      (stat[i])
        );
    end

    // the lt flags form a thermometer, its edge is the sorted slot
    always_comb begin
        found = 1'b0;
        slot  = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            found = found | stat[i].eq;
            if (!stat[i].lt && left_lt[i]) begin
                slot = slot | IDX_W'(i);
            end
        end
        full = stat[CAPACITY-1].vld;
    end

    always_comb begin
        dec_op   = OP_NONE;
        dec_stat = STAT_NOCHG;
        unique case (r_kind)
            KIND_INS: begin
                if (found) begin
                    dec_stat = STAT_NOCHG;
                end else if (full) begin
                    dec_stat = STAT_FULL;
                end else begin
                    dec_stat = STAT_DONE;
                    dec_op   = OP_INS;
                end
            end
            KIND_DEL: begin
                if (found) begin
                    dec_stat = STAT_DONE;
                    dec_op   = OP_DEL;
                end
            end
            KIND_SRCH: begin
                if (found) begin
                    dec_stat = STAT_DONE;
                end
            end
            default: begin
                dec_stat = STAT_NOCHG;
                dec_op   = OP_NONE;
            end
        endcase
    end

    assign key_ext = SUM_W'(r_key);

    always_comb begin
        n_count = r_count;
        unique case (r_op)
            OP_INS:  n_count = r_count + CNT_W'(1);
            OP_DEL:  n_count = r_count - CNT_W'(1);
            default: n_count = r_count;
        endcase
        n_sum = r_sum + r_delta;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (in_beat) n_state = ST_CMP;
            ST_CMP:  n_state = ST_DEC;
            ST_DEC:  n_state = ST_UPD;
            ST_UPD:  if (upd_fire) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_kind <= i_kind;
            r_key  <= VALUE_WIDTH'(i_value);
        end
        if (r_state == ST_DEC) begin
            r_stat <= dec_stat;
            r_pos  <= (dec_stat == STAT_DONE) ? slot : '0;
            unique case (dec_op)
                OP_INS:  r_delta <= key_ext;
                OP_DEL:  r_delta <= -key_ext;
                default: r_delta <= '0;
            endcase
        end
        if (upd_fire) begin
            r_o_status <= r_stat;
            r_o_pos    <= POS_W'(r_pos);
            r_o_count  <= CNT_OUT_W'(n_count);
            r_o_sum    <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_op     <= OP_NONE;
            r_count  <= '0;
            r_sum    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_DEC) begin
                r_op <= dec_op;
            end
            if (upd_fire) begin
                r_count  <= n_count;
                r_sum    <= n_sum;
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_valid        = r_ovalid;
    assign o_status       = r_o_status;
    assign o_position     = r_o_pos;
    assign o_member_count = r_o_count;
    assign o_member_sum   = r_o_sum;

endmodule

`default_nettype wire
